[rtl/ecsr_pkg.sv]
// shared constants and types for the edge list to csr builder
package ecsr_pkg;

  localparam int MAX_VERTS = 1024;
  localparam int MAX_EDGES = 4096;

  localparam int VW  = $clog2(MAX_VERTS);      // vertex id bits
  localparam int NW  = VW + 1;                 // vertex count bits
  localparam int EAW = $clog2(MAX_EDGES);      // edge store address bits
  localparam int EW  = EAW + 1;                // edge count bits

  localparam logic [2:0] FN_ADD     = 3'd0;
  localparam logic [2:0] FN_BUILD   = 3'd1;
  localparam logic [2:0] FN_RD_OFF  = 3'd2;
  localparam logic [2:0] FN_RD_ADJ  = 3'd3;
  localparam logic [2:0] FN_CLEAR   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_BAD_VERT  = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX = 3'd3;
  localparam logic [2:0] ST_NO_EDGES  = 3'd4;
  localparam logic [2:0] ST_NOT_BUILT = 3'd5;

  typedef struct packed {
    logic clear;
    logic update;
  } max_ctl_t;

endpackage

[rtl/ecsr_max_trk.sv]
// running maximum of degree; on ties the vertex offered first is kept
module ecsr_max_trk (
  input  logic                    clk,
  input  ecsr_pkg::max_ctl_t      ctl,
  input  logic [ecsr_pkg::EW-1:0] degree,
  input  logic [ecsr_pkg::VW-1:0] vertex,
  output logic [ecsr_pkg::EW-1:0] best_degree,
  output logic [ecsr_pkg::VW-1:0] best_vertex
);

  logic [ecsr_pkg::EW-1:0] best_r;
  logic [ecsr_pkg::VW-1:0] bestv_r;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      best_r  <= '0;
      bestv_r <= '0;
    end else if (ctl.update && (degree > best_r)) begin
      best_r  <= degree;
      bestv_r <= vertex;
    end
  end

  assign best_degree = best_r;
  assign best_vertex = bestv_r;

endmodule

[rtl/edge_list_to_csr_builder.sv]
// top level: edge store, csr build sequencer and read port
// add edge, clear and error results go straight from the transfer into the result register.
// reads pass through the registered memory read and then the result register.
// build checks every edge, clears the degrees, counts, takes the prefix sum and scatters,
// each pass paced by the single-port read of each store and the read-modify-write of the degree cursors.
// one item at a time; in_stall high while busy or result waits.
// synchronous active-low reset clears edge count, built flag, sequencer and result valid.
module edge_list_to_csr_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [9:0]  in_src_vertex,
  input  logic [9:0]  in_dst_vertex,
  input  logic [12:0] in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] out_value,
  output logic [9:0]  out_max_vertex,
  output logic [12:0] out_peak_degree,
  output logic [2:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_num_vertices
);

  localparam int VW  = ecsr_pkg::VW;
  localparam int NW  = ecsr_pkg::NW;
  localparam int EAW = ecsr_pkg::EAW;
  localparam int EW  = ecsr_pkg::EW;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RD    = 13'b0000000000010,
    S_CHK_A = 13'b0000000000100,
    S_CHK_B = 13'b0000000001000,
    S_CLR   = 13'b0000000010000,
    S_CNT_A = 13'b0000000100000,
    S_CNT_B = 13'b0000001000000,
    S_CNT_C = 13'b0000010000000,
    S_PFX_A = 13'b0000100000000,
    S_PFX_B = 13'b0001000000000,
    S_SCT_A = 13'b0010000000000,
    S_SCT_B = 13'b0100000000000,
    S_SCT_C = 13'b1000000000000
  } state_t;

  // memories
  logic [VW-1:0] src_mem [ecsr_pkg::MAX_EDGES];
  logic [VW-1:0] dst_mem [ecsr_pkg::MAX_EDGES];
  logic [VW-1:0] adj_mem [ecsr_pkg::MAX_EDGES];
  logic [EW-1:0] deg_mem [ecsr_pkg::MAX_VERTS];
  logic [EW-1:0] ro_mem  [ecsr_pkg::MAX_VERTS + 1];

  state_t        state_r, state_nxt;
  logic [NW-1:0] nv_r, nv_nxt;
  logic [EW-1:0] ec_r, ec_nxt;
  logic          built_r, built_nxt;
  logic [EAW-1:0] i_r, i_nxt;
  logic [NW-1:0] j_r, j_nxt;
  logic [EW-1:0] acc_r, acc_nxt;
  logic          rd_adj_r, rd_adj_nxt;

  logic          ov_r, ov_nxt;
  logic [EW-1:0] oval_r, oval_nxt;
  logic [VW-1:0] omv_r, omv_nxt;
  logic [EW-1:0] omd_r, omd_nxt;
  logic [2:0]    ost_r, ost_nxt;

  logic [VW-1:0] src_rd_r, dst_rd_r, adj_rd_r;
  logic [EW-1:0] deg_rd_r, ro_rd_r;

  logic          es_we;
  logic [VW-1:0] deg_raddr, deg_waddr;
  logic          deg_we;
  logic [EW-1:0] deg_wdata;
  logic          ro_we;
  logic [NW-1:0] ro_waddr;
  logic          adj_we;

  logic [NW-1:0] n_act;
  logic          in_xfer, cfg_xfer, last_edge, last_vert;
  logic [EW-1:0] add_a, add_b, add_sum;

  ecsr_pkg::max_ctl_t      mctl;
  logic [EW-1:0]           best_deg;
  logic [VW-1:0]           best_vert;

  assign in_xfer  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_xfer = cfg_valid && cfg_ready;
  assign in_stall = (state_r != S_IDLE) || ov_r;

  always_comb begin
    if (nv_r == '0) n_act = NW'(1);
    else if (nv_r > NW'(ecsr_pkg::MAX_VERTS)) n_act = NW'(ecsr_pkg::MAX_VERTS);
    else n_act = nv_r;
  end

  assign last_edge = ({1'b0, i_r} == (ec_r - EW'(1)));
  assign last_vert = (j_r == (n_act - NW'(1)));

  // shared data adder
  always_comb begin
    add_a = deg_rd_r;
    add_b = EW'(1);
    if (state_r == S_PFX_B) begin
      add_a = acc_r;
      add_b = deg_rd_r;
    end
  end
  assign add_sum = add_a + add_b;

  always_comb begin
    deg_raddr = (state_r == S_PFX_A) ? j_r[VW-1:0] : src_rd_r;
    deg_we    = 1'b0;
    deg_waddr = src_rd_r;
    deg_wdata = add_sum;
    ro_we     = 1'b0;
    ro_waddr  = j_r + NW'(1);
    adj_we    = (state_r == S_SCT_C);
    mctl      = '{clear: 1'b0, update: 1'b0};
    unique case (state_r) inside
      S_CLR: begin
        deg_we    = 1'b1;
        deg_waddr = j_r[VW-1:0];
        deg_wdata = '0;
        ro_we     = (j_r == '0);
        ro_waddr  = '0;
        mctl.clear = 1'b1;
      end
      S_CNT_C, S_SCT_C: deg_we = 1'b1;
      S_PFX_B: begin
        deg_we    = 1'b1;
        deg_waddr = j_r[VW-1:0];
        deg_wdata = acc_r;
        ro_we     = 1'b1;
        mctl.update = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (es_we) begin
      src_mem[ec_r[EAW-1:0]] <= in_src_vertex;
      dst_mem[ec_r[EAW-1:0]] <= in_dst_vertex;
    end
    src_rd_r <= src_mem[i_r];
    dst_rd_r <= dst_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    deg_rd_r <= deg_mem[deg_raddr];
  end

  always_ff @(posedge clk) begin
    if (ro_we) ro_mem[ro_waddr] <= (state_r == S_CLR) ? '0 : add_sum;
    ro_rd_r <= ro_mem[in_read_index[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[deg_rd_r[EAW-1:0]] <= dst_rd_r;
    adj_rd_r <= adj_mem[in_read_index[EAW-1:0]];
  end

  ecsr_max_trk u_max (
    .clk         (clk),
    .ctl         (mctl),
    .degree      (deg_rd_r),
    .vertex      (j_r[VW-1:0]),
    .best_degree (best_deg),
    .best_vertex (best_vert)
  );

  always_comb begin
    state_nxt  = state_r;
    nv_nxt     = nv_r;
    ec_nxt     = ec_r;
    built_nxt  = built_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    acc_nxt    = acc_r;
    rd_adj_nxt = rd_adj_r;
    ov_nxt     = ov_r && out_stall;
    oval_nxt   = oval_r;
    omv_nxt    = omv_r;
    omd_nxt    = omd_r;
    ost_nxt    = ost_r;
    es_we      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          ov_nxt   = 1'b1;
          oval_nxt = '0;
          omv_nxt  = '0;
          omd_nxt  = '0;
          ost_nxt  = ecsr_pkg::ST_OK;
          case (in_func) inside
            ecsr_pkg::FN_ADD: begin
              if (ec_r == EW'(ecsr_pkg::MAX_EDGES)) begin
                ost_nxt = ecsr_pkg::ST_FULL;
                oval_nxt = ec_r;
              end else if ({1'b0, in_src_vertex} >= n_act ||
                           {1'b0, in_dst_vertex} >= n_act) begin
                ost_nxt = ecsr_pkg::ST_BAD_VERT;
                oval_nxt = ec_r;
              end else begin
                es_we     = 1'b1;
                ec_nxt    = ec_r + EW'(1);
                oval_nxt  = ec_r + EW'(1);
                built_nxt = 1'b0;
              end
            end
            ecsr_pkg::FN_BUILD: begin
              built_nxt = 1'b0;
              if (ec_r == '0) begin
                ost_nxt = ecsr_pkg::ST_NO_EDGES;
              end else begin
                ov_nxt    = 1'b0;
                i_nxt     = '0;
                state_nxt = S_CHK_A;
              end
            end
            ecsr_pkg::FN_RD_OFF, ecsr_pkg::FN_RD_ADJ: begin
              if (!built_r) begin
                ost_nxt = ecsr_pkg::ST_NOT_BUILT;
              end else if ((in_func == ecsr_pkg::FN_RD_OFF) ?
                           (in_read_index > EW'(n_act)) : (in_read_index >= ec_r)) begin
                ost_nxt = ecsr_pkg::ST_BAD_INDEX;
              end else begin
                ov_nxt     = 1'b0;
                rd_adj_nxt = (in_func == ecsr_pkg::FN_RD_ADJ);
                state_nxt  = S_RD;
              end
            end
            ecsr_pkg::FN_CLEAR: begin
              ec_nxt    = '0;
              built_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        ov_nxt    = 1'b1;
        oval_nxt  = rd_adj_r ? {{(EW-VW){1'b0}}, adj_rd_r} : ro_rd_r;
        state_nxt = S_IDLE;
      end
      S_CHK_A: state_nxt = S_CHK_B;
      S_CHK_B: begin
        if ({1'b0, src_rd_r} >= n_act || {1'b0, dst_rd_r} >= n_act) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ecsr_pkg::ST_BAD_VERT;
          oval_nxt  = ec_r;
          state_nxt = S_IDLE;
        end else if (last_edge) begin
          j_nxt     = '0;
          state_nxt = S_CLR;
        end else begin
          i_nxt     = i_r + EAW'(1);
          state_nxt = S_CHK_A;
        end
      end
      S_CLR: begin
        if (last_vert) begin
          i_nxt     = '0;
          state_nxt = S_CNT_A;
        end else begin
          j_nxt = j_r + NW'(1);
        end
      end
      S_CNT_A: state_nxt = S_CNT_B;
      S_CNT_B: state_nxt = S_CNT_C;
      S_CNT_C: begin
        if (last_edge) begin
          j_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_PFX_A;
        end else begin
          i_nxt     = i_r + EAW'(1);
          state_nxt = S_CNT_A;
        end
      end
      S_PFX_A: state_nxt = S_PFX_B;
      S_PFX_B: begin
        acc_nxt = add_sum;
        if (last_vert) begin
          i_nxt     = '0;
          state_nxt = S_SCT_A;
        end else begin
          j_nxt     = j_r + NW'(1);
          state_nxt = S_PFX_A;
        end
      end
      S_SCT_A: state_nxt = S_SCT_B;
      S_SCT_B: state_nxt = S_SCT_C;
      S_SCT_C: begin
        if (last_edge) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ecsr_pkg::ST_OK;
          oval_nxt  = ec_r;
          omv_nxt   = best_vert;
          omd_nxt   = best_deg;
          built_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r + EAW'(1);
          state_nxt = S_SCT_A;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_xfer) begin
      nv_nxt    = cfg_num_vertices;
      built_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nv_r    <= NW'(ecsr_pkg::MAX_VERTS);
      ec_r    <= '0;
      built_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nv_r    <= nv_nxt;
      ec_r    <= ec_nxt;
      built_r <= built_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    acc_r    <= acc_nxt;
    rd_adj_r <= rd_adj_nxt;
    oval_r   <= oval_nxt;
    omv_r    <= omv_nxt;
    omd_r    <= omd_nxt;
    ost_r    <= ost_nxt;
  end

  assign out_valid       = ov_r;
  assign out_value       = oval_r;
  assign out_max_vertex  = omv_r;
  assign out_peak_degree = omd_r;
  assign out_status      = ost_r;

endmodule

[rtl/ecsr_checker.sv]
// port-level checks for the csr builder, bound to the top level
module ecsr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [12:0] out_value,
  input logic [9:0]  out_max_vertex,
  input logic [12:0] out_peak_degree,
  input logic [2:0]  out_status
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("stalled result changed");

  // one item at a time: busy right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // max fields only on a successful build
  a_max_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ecsr_pkg::ST_OK |->
      out_max_vertex == '0 && out_peak_degree == '0)
    else $error("max fields set on error result");

  // result pending means input side is held off
  a_stall_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

endmodule

bind edge_list_to_csr_builder ecsr_checker u_ecsr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_value       (out_value),
  .out_max_vertex  (out_max_vertex),
  .out_peak_degree (out_peak_degree),
  .out_status      (out_status)
);

[bench/tb_edge_list_to_csr_builder.sv]
// self-checking bench for the edge list to csr builder
module tb_edge_list_to_csr_builder;
  timeunit 1ns;
  timeprecision 1ps;

  // function codes the block does not use
  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [12:0] value;
    logic [9:0]  max_vertex;
    logic [12:0] peak_degree;
    logic [2:0]  status;
  } csr_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_func;
  logic [9:0]  in_src_vertex;
  logic [9:0]  in_dst_vertex;
  logic [12:0] in_read_index;
  logic        out_valid;
  logic        out_stall;
  logic [12:0] out_value;
  logic [9:0]  out_max_vertex;
  logic [12:0] out_peak_degree;
  logic [2:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_num_vertices;

  edge_list_to_csr_builder uut (.*);

  // shadow state of the block
  logic [9:0]  src_mem [ecsr_pkg::MAX_EDGES];
  logic [9:0]  dst_mem [ecsr_pkg::MAX_EDGES];
  logic [12:0] offset_mem [ecsr_pkg::MAX_VERTS+1];
  logic [9:0]  adj_mem [ecsr_pkg::MAX_EDGES];
  int          n_edges;
  bit          csr_valid;
  logic [10:0] vert_reg;

  csr_result_t expected_results[$];
  int  errors;
  longint cycles;
  bit  stall_enable;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // large limit: each build walks all edges and all vertices
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int vert_in_use();
    if (vert_reg == 0) return 1;
    if (vert_reg > ecsr_pkg::MAX_VERTS) return ecsr_pkg::MAX_VERTS;
    return vert_reg;
  endfunction

  function automatic csr_result_t predict_csr(logic [2:0] f, logic [9:0] s, logic [9:0] d,
                                              logic [12:0] idx);
    csr_result_t r;
    int n, deg[ecsr_pkg::MAX_VERTS], cur[ecsr_pkg::MAX_VERTS], best, bestv;
    bit bad;
    r = '0;
    n = vert_in_use();
    case (f)
      ecsr_pkg::FN_ADD: begin
        if (n_edges >= ecsr_pkg::MAX_EDGES) r.status = ecsr_pkg::ST_FULL;
        else if (s >= n || d >= n) r.status = ecsr_pkg::ST_BAD_VERT;
        else begin
          src_mem[n_edges] = s;
          dst_mem[n_edges] = d;
          n_edges++;
          csr_valid = 0;
        end
        r.value = 13'(n_edges);
      end
      ecsr_pkg::FN_BUILD: begin
        csr_valid = 0;
        bad = 0;
        if (n_edges == 0) r.status = ecsr_pkg::ST_NO_EDGES;
        else begin
          for (int i = 0; i < n_edges; i++)
            if (src_mem[i] >= n || dst_mem[i] >= n) bad = 1;
          r.value = 13'(n_edges);
          if (bad) r.status = ecsr_pkg::ST_BAD_VERT;
          else begin
            for (int i = 0; i < ecsr_pkg::MAX_VERTS; i++) deg[i] = 0;
            for (int i = 0; i < n_edges; i++) deg[src_mem[i]]++;
            offset_mem[0] = 0;
            for (int i = 0; i < n; i++) offset_mem[i+1] = 13'(offset_mem[i] + deg[i]);
            for (int i = 0; i < n; i++) cur[i] = offset_mem[i];
            for (int i = 0; i < n_edges; i++) begin
              adj_mem[cur[src_mem[i]]] = dst_mem[i];
              cur[src_mem[i]]++;
            end
            best = 0;
            bestv = 0;
            for (int i = 0; i < n; i++)
              if (deg[i] > best) begin
                best = deg[i];
                bestv = i;
              end
            r.max_vertex = 10'(bestv);
            r.peak_degree = 13'(best);
            csr_valid = 1;
          end
        end
      end
      ecsr_pkg::FN_RD_OFF: begin
        if (!csr_valid) r.status = ecsr_pkg::ST_NOT_BUILT;
        else if (idx > n) r.status = ecsr_pkg::ST_BAD_INDEX;
        else r.value = offset_mem[idx];
      end
      ecsr_pkg::FN_RD_ADJ: begin
        if (!csr_valid) r.status = ecsr_pkg::ST_NOT_BUILT;
        else if (idx >= n_edges) r.status = ecsr_pkg::ST_BAD_INDEX;
        else r.value = adj_mem[idx];
      end
      ecsr_pkg::FN_CLEAR: begin
        n_edges = 0;
        csr_valid = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // valid stays high past a transfer only when the next item follows at once
  task automatic send_item(logic [2:0] f, logic [9:0] s, logic [9:0] d, logic [12:0] idx);
    int gap;
    gap = stall_enable ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_src_vertex <= s;
    in_dst_vertex <= d;
    in_read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_csr(f, s, d, idx));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_vertex_count(logic [10:0] v);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_num_vertices <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    vert_reg = v;
    csr_valid = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker, random receiver stall
  always @(posedge clk) begin
    csr_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result value %0d status %0d", $realtime, out_value,
                 out_status);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.value !== out_value) begin
          $display("%0t value exp %0d got %0d", $realtime, exp_r.value, out_value);
          errors++;
        end
        if (exp_r.max_vertex !== out_max_vertex) begin
          $display("%0t max_vertex exp %0d got %0d", $realtime, exp_r.max_vertex,
                   out_max_vertex);
          errors++;
        end
        if (exp_r.peak_degree !== out_peak_degree) begin
          $display("%0t peak_degree exp %0d got %0d", $realtime, exp_r.peak_degree,
                   out_peak_degree);
          errors++;
        end
        if (exp_r.status !== out_status) begin
          $display("%0t status exp %0d got %0d", $realtime, exp_r.status, out_status);
          errors++;
        end
      end
    end
  end

  int stall_left;
  always @(negedge clk) begin
    if (!stall_enable) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      stall_left <= $urandom_range(0, 10);
      out_stall <= 1'b0;
    end else out_stall <= 1'b0;
  end

  task automatic test_errors_before_build();
    send_item(ecsr_pkg::FN_BUILD, 0, 0, 0);
    send_item(ecsr_pkg::FN_RD_OFF, 0, 0, 0);
    send_item(ecsr_pkg::FN_RD_ADJ, 0, 0, 0);
    send_item(FN_SPARE_LO, 10'h3ff, 10'h3ff, 13'h1fff);
    send_item(FN_SPARE_HI, 0, 0, 0);
  endtask

  task automatic test_small_graph();
    send_item(ecsr_pkg::FN_ADD, 0, 1023, 0);
    send_item(ecsr_pkg::FN_ADD, 1023, 0, 0);
    send_item(ecsr_pkg::FN_ADD, 5, 7, 0);
    send_item(ecsr_pkg::FN_ADD, 5, 9, 0);
    send_item(ecsr_pkg::FN_BUILD, 0, 0, 0);
    send_item(ecsr_pkg::FN_RD_OFF, 0, 0, 0);
    send_item(ecsr_pkg::FN_RD_OFF, 0, 0, 1024);
    send_item(ecsr_pkg::FN_RD_OFF, 0, 0, 1025);
    send_item(ecsr_pkg::FN_RD_OFF, 0, 0, 13'h1fff);
    send_item(ecsr_pkg::FN_RD_ADJ, 0, 0, 3);
    send_item(ecsr_pkg::FN_RD_ADJ, 0, 0, 4);
    send_item(ecsr_pkg::FN_ADD, 2, 3, 0);
    send_item(ecsr_pkg::FN_RD_ADJ, 0, 0, 0);
  endtask

  task automatic test_bad_vertex();
    write_vertex_count(11'd8);
    send_item(ecsr_pkg::FN_ADD, 8, 0, 0);
    send_item(ecsr_pkg::FN_ADD, 0, 8, 0);
    send_item(ecsr_pkg::FN_BUILD, 0, 0, 0);
    send_item(ecsr_pkg::FN_CLEAR, 0, 0, 0);
    send_item(ecsr_pkg::FN_ADD, 7, 7, 0);
    send_item(ecsr_pkg::FN_BUILD, 0, 0, 0);
    send_item(ecsr_pkg::FN_RD_OFF, 0, 0, 8);
    send_item(ecsr_pkg::FN_RD_OFF, 0, 0, 9);
  endtask

  task automatic test_register_extremes();
    write_vertex_count(11'd0);
    send_item(ecsr_pkg::FN_ADD, 1, 0, 0);
    send_item(ecsr_pkg::FN_ADD, 0, 0, 0);
    send_item(ecsr_pkg::FN_BUILD, 0, 0, 0);
    send_item(ecsr_pkg::FN_RD_OFF, 0, 0, 1);
    write_vertex_count(11'h7ff);
    send_item(ecsr_pkg::FN_ADD, 1023, 1023, 0);
    send_item(ecsr_pkg::FN_BUILD, 0, 0, 0);
    send_item(ecsr_pkg::FN_CLEAR, 0, 0, 0);
  endtask

  task automatic test_random_graphs();
    int n, k, r;
    for (int g = 0; g < 36; g++) begin
      if (g % 6 == 0) begin
        stall_enable = (g % 12 != 0);
        r = $urandom_range(0, 3);
        n = (r == 0) ? 1 : (r == 1) ? 1024 : $urandom_range(2, 64);
        write_vertex_count(11'(n));
      end
      n = vert_in_use();
      send_item(ecsr_pkg::FN_CLEAR, 0, 0, 0);
      k = $urandom_range(1, 12);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(ecsr_pkg::FN_ADD, 10'($urandom), 10'($urandom), 13'($urandom));
        else
          send_item(ecsr_pkg::FN_ADD, 10'($urandom_range(0, n - 1)),
                    10'($urandom_range(0, n - 1)), 13'($urandom));
      end
      send_item(ecsr_pkg::FN_BUILD, 10'($urandom), 10'($urandom), 13'($urandom));
      for (int i = 0; i < 6; i++) begin
        r = $urandom_range(0, 7);
        if (r < 3)
          send_item(ecsr_pkg::FN_RD_OFF, 10'($urandom), 10'($urandom),
                    13'($urandom_range(0, n + 1)));
        else if (r < 6)
          send_item(ecsr_pkg::FN_RD_ADJ, 10'($urandom), 10'($urandom),
                    13'($urandom_range(0, k)));
        else send_item(3'($urandom), 10'($urandom), 10'($urandom), 13'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_src_vertex = '0;
    in_dst_vertex = '0;
    in_read_index = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_num_vertices = 11'd1024;
    n_edges = 0;
    csr_valid = 0;
    vert_reg = 11'd1024;
    errors = 0;
    cycles = 0;
    stall_left = 0;
    stall_enable = 1;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_errors_before_build();
    test_small_graph();
    test_bad_vertex();
    test_register_extremes();
    test_random_graphs();
    wait_drain();
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
